@@ rtl/qf_pkg.sv @@
// Package for the quotient filter: sizes, field types, controller/datapath links.
// No dependencies.
`default_nettype none
package qf_pkg;
  localparam int SLOTS = 64;
  localparam int QUOTIENT_BITS = 6;
  localparam int REMAINDER_BITS = 26;
  localparam int KEY_BITS = 32;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_QUERY = 1'b1;
  localparam logic STATUS_OK = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef logic [KEY_BITS-1:0] key_t;
  typedef logic [REMAINDER_BITS-1:0] rem_t;
  typedef logic [SLOTS-1:0] bits_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [SLOT_W-1:0] slot_t;

  typedef struct packed {
    logic load;       // capture the item, clear the counters
    logic rank_step;  // one slot of the occupied rank count
    logic sel_step;   // one slot of the run-end select / first-free scan
    logic shift_step; // one slot of the right shift
    logic reject;     // insert refused, block full
    logic commit;     // write the remainder, update the bit vectors
    logic query_step; // one slot of the run scan
  } qf_cmd_t;

  typedef struct packed {
    logic rank_last;
    logic scan_end;
    logic sel_hit;
    logic sel_free;
    logic new_run;
    logic full;
    logic shift_done;
    logic query_done;
  } qf_sts_t;
endpackage
`default_nettype wire

@@ rtl/qf_if.sv @@
// Valid/ready channel interfaces for items and results.
// Depends on qf_pkg.
`default_nettype none
interface qf_in_if;
  logic valid;
  logic ready;
  logic mode;
  logic [qf_pkg::KEY_BITS-1:0] key;
  modport source (output valid, output mode, output key, input ready);
  modport sink (input valid, input mode, input key, output ready);
endinterface

interface qf_out_if;
  logic valid;
  logic ready;
  logic found;
  logic status;
  modport source (output valid, output found, output status, input ready);
  modport sink (input valid, input found, input status, output ready);
endinterface
`default_nettype wire

@@ rtl/qf_ram.sv @@
// Generic single-port-write, one-read RAM with registered read.
// No dependencies.
`default_nettype none
module qf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ rtl/qf_datapath.sv @@
// Datapath: bit vectors, slot scan counters, remainder RAM.
// Depends on qf_pkg and qf_ram.
`default_nettype none
module qf_datapath (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire qf_pkg::qf_cmd_t cmd,
  input  wire qf_pkg::key_t    in_key,
  output qf_pkg::qf_sts_t      sts,
  output logic                 found,
  output logic                 status
);
  import qf_pkg::*;

  bits_t occ_r, occ_nxt, rend_r, rend_nxt;
  rem_t rem_r;
  slot_t q_r;
  slot_t i_r;       // scan slot
  slot_t e_r;       // end of the t-th run, the home run when occupied
  slot_t sh_r;      // shift pointer, starts at the first free slot
  slot_t qptr_r;    // run scan pointer
  logic e_ok_r, fr_ok_r, rd_pend_r, hit_r, miss_r, status_r;
  cnt_t t_r;        // occupied rank at home
  cnt_t ec_r;       // run ends before the scan slot
  cnt_t oc_r;       // occupied bits before the scan slot

  slot_t p_s, sh_m1, sh_m2, qptr_m1;
  logic e_hit, free_hit, new_run;
  logic ram_we;
  slot_t ram_waddr, ram_raddr;
  rem_t ram_wdata, ram_rdata;

  assign p_s = e_r + slot_t'(1);
  assign sh_m1 = sh_r - slot_t'(1);
  assign sh_m2 = sh_r - slot_t'(2);
  assign qptr_m1 = qptr_r - slot_t'(1);

  // t-th run end; first slot past it that no run covers
  assign e_hit = !e_ok_r && rend_r[i_r] && (ec_r + cnt_t'(1) == t_r);
  assign free_hit = e_ok_r && !fr_ok_r && (i_r > e_r)
                    && (ec_r >= oc_r + cnt_t'(occ_r[i_r]));
  assign new_run = !occ_r[q_r] && (t_r == '0 || (e_ok_r && e_r < q_r));

  always_comb begin
    ram_we = 1'b0;
    ram_waddr = sh_r;
    ram_wdata = ram_rdata;
    ram_raddr = qptr_r;
    if (cmd.shift_step) begin
      ram_raddr = rd_pend_r ? sh_m2 : sh_m1;
      ram_we = rd_pend_r;
    end
    if (cmd.query_step) begin
      ram_raddr = rd_pend_r ? qptr_m1 : qptr_r;
    end
    if (cmd.commit) begin
      ram_we = 1'b1;
      ram_waddr = new_run ? q_r : p_s;
      ram_wdata = rem_r;
    end
  end

  qf_ram #(.WIDTH(REMAINDER_BITS), .DEPTH(SLOTS)) u_ram (
    .clk, .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
      rend_r <= '0;
      rem_r <= '0;
      q_r <= '0;
      i_r <= '0;
      e_r <= '0;
      sh_r <= '0;
      qptr_r <= '0;
      e_ok_r <= 1'b0;
      fr_ok_r <= 1'b0;
      rd_pend_r <= 1'b0;
      hit_r <= 1'b0;
      miss_r <= 1'b0;
      status_r <= STATUS_OK;
      t_r <= '0;
      ec_r <= '0;
      oc_r <= '0;
    end else begin
      occ_r <= occ_nxt;
      rend_r <= rend_nxt;
      if (cmd.load) begin
        rem_r <= in_key[REMAINDER_BITS-1:0];
        q_r <= in_key[REMAINDER_BITS +: QUOTIENT_BITS];
        i_r <= '0;
        e_r <= '0;
        sh_r <= '0;
        qptr_r <= '0;
        e_ok_r <= 1'b0;
        fr_ok_r <= 1'b0;
        rd_pend_r <= 1'b0;
        hit_r <= 1'b0;
        miss_r <= 1'b0;
        status_r <= STATUS_OK;
        t_r <= '0;
        ec_r <= '0;
        oc_r <= '0;
      end else if (cmd.rank_step) begin
        if (occ_r[i_r]) t_r <= t_r + cnt_t'(1);
        i_r <= (i_r == q_r) ? '0 : i_r + slot_t'(1);
      end else if (cmd.sel_step) begin
        if (rend_r[i_r]) ec_r <= ec_r + cnt_t'(1);
        if (occ_r[i_r]) oc_r <= oc_r + cnt_t'(1);
        if (e_hit) begin
          e_r <= i_r;
          e_ok_r <= 1'b1;
          qptr_r <= i_r;
        end
        if (free_hit) begin
          sh_r <= i_r;
          fr_ok_r <= 1'b1;
        end
        i_r <= i_r + slot_t'(1);
      end else if (cmd.shift_step) begin
        rd_pend_r <= 1'b1;
        if (rd_pend_r) sh_r <= sh_m1;
      end else if (cmd.reject) begin
        status_r <= STATUS_FULL;
      end else if (cmd.query_step) begin
        rd_pend_r <= 1'b1;
        if (rd_pend_r) begin
          if (ram_rdata == rem_r) begin
            hit_r <= 1'b1;
          end else if (qptr_r == '0 || qptr_m1 < q_r || rend_r[qptr_m1]) begin
            miss_r <= 1'b1;
          end else begin
            qptr_r <= qptr_m1;
          end
        end
      end
    end
  end

  always_comb begin
    occ_nxt = occ_r;
    rend_nxt = rend_r;
    if (cmd.shift_step && rd_pend_r) begin
      rend_nxt[sh_r] = rend_r[sh_m1];
    end
    if (cmd.commit) begin
      occ_nxt[q_r] = 1'b1;
      if (new_run) begin
        rend_nxt[q_r] = 1'b1;
      end else begin
        if (occ_r[q_r]) rend_nxt[e_r] = 1'b0;
        rend_nxt[p_s] = 1'b1;
      end
    end
  end

  assign sts.rank_last = (i_r == q_r);
  assign sts.scan_end = (i_r == slot_t'(SLOTS - 1));
  assign sts.sel_hit = e_hit;
  assign sts.sel_free = free_hit;
  assign sts.new_run = new_run;
  assign sts.full = !new_run && !(e_ok_r && fr_ok_r);
  assign sts.shift_done = (sh_r == p_s);
  assign sts.query_done = hit_r || miss_r || !occ_r[q_r] || !e_ok_r;
  assign found = hit_r;
  assign status = status_r;
endmodule
`default_nettype wire

@@ rtl/qf_ctrl.sv @@
// Controller state machine sequencing rank, select, shift, commit and run scan.
// Depends on qf_pkg.
`default_nettype none
module qf_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic            in_mode,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output qf_pkg::qf_cmd_t      cmd,
  input  wire qf_pkg::qf_sts_t sts
);
  import qf_pkg::*;
  typedef enum logic [2:0] {
    S_IDLE, S_RANK, S_SELECT, S_SHIFT, S_COMMIT, S_QUERY, S_DONE
  } state_t;
  state_t state_r;
  logic mode_r;
  logic sel_last;

  assign in_ready = (state_r == S_IDLE);
  assign sel_last = sts.scan_end || ((mode_r == MODE_QUERY) ? sts.sel_hit : sts.sel_free);

  always_comb begin
    cmd = '0;
    unique case (state_r)
      S_IDLE: cmd.load = in_valid;
      S_RANK: cmd.rank_step = 1'b1;
      S_SELECT: cmd.sel_step = 1'b1;
      S_SHIFT: begin
        if (sts.full) cmd.reject = 1'b1;
        else if (!sts.new_run && !sts.shift_done) cmd.shift_step = 1'b1;
      end
      S_COMMIT: cmd.commit = 1'b1;
      S_QUERY: cmd.query_step = !sts.query_done;
      S_DONE: cmd = '0;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid <= 1'b0;
      mode_r <= MODE_INSERT;
    end else begin
      unique case (state_r)
        S_IDLE: if (in_valid) begin
          mode_r <= in_mode;
          state_r <= S_RANK;
        end
        S_RANK: if (sts.rank_last) state_r <= S_SELECT;
        S_SELECT: if (sel_last) begin
          state_r <= (mode_r == MODE_QUERY) ? S_QUERY : S_SHIFT;
        end
        S_SHIFT: begin
          if (sts.full) begin
            state_r <= S_DONE;
            out_valid <= 1'b1;
          end else if (sts.new_run || sts.shift_done) begin
            state_r <= S_COMMIT;
          end
        end
        S_COMMIT: begin
          state_r <= S_DONE;
          out_valid <= 1'b1;
        end
        S_QUERY: if (sts.query_done) begin
          state_r <= S_DONE;
          out_valid <= 1'b1;
        end
        S_DONE: if (out_ready) begin
          out_valid <= 1'b0;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_one_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("accept while result pending");
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> state_r == S_IDLE) else $error("load outside idle");
  a_done_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) == out_valid) else $error("result valid mismatch");
endmodule
`default_nettype wire

@@ rtl/quotient_filter_insert_query.sv @@
// Top level of the quotient filter: channels, controller, datapath.
// Depends on qf_pkg, qf_if, qf_ctrl, qf_datapath.
//  channel | dir | carries
//  in_     | in  | mode, key
//  out_    | out | found, status
// One item at a time: take it, count the occupied rank up to home, then scan for
// the home run end and, for an insert, the first free slot. Insert: refuse if the
// block is full, else shift the slots that move, then commit the remainder.
// Query: compare the remainders of the home run, if it is present.
// Reset (rst_n, synchronous) clears both bit vectors; the RAM needs no clear.
// A stalled result holds the block; no new item is taken until it transfers.
`default_nettype none
module quotient_filter_insert_query (
  input wire logic clk,
  input wire logic rst_n,
  qf_in_if.sink    in_ch,
  qf_out_if.source out_ch
);
  import qf_pkg::*;
  qf_cmd_t cmd;
  qf_sts_t sts;

  qf_ctrl u_ctrl (
    .clk, .rst_n, .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_mode(in_ch.mode),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .cmd, .sts
  );
  qf_datapath u_dp (
    .clk, .rst_n, .cmd, .in_key(in_ch.key), .sts,
    .found(out_ch.found), .status(out_ch.status)
  );
endmodule
`default_nettype wire
